@@ rtl/button_autorepeat_navigator_defines.svh @@
// Assertion macros for the navigator RTL.
// Define SYNTH to compile them out.
`ifndef BUTTON_AUTOREPEAT_NAVIGATOR_DEFINES_SVH
`define BUTTON_AUTOREPEAT_NAVIGATOR_DEFINES_SVH

`ifndef SYNTH
`define BAN_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define BAN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BAN_ASSERT_IMPL(label, ante, cons)
`define BAN_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/ban_pkg.sv @@
`timescale 1ns / 1ps
package ban_pkg;

	typedef enum logic [2:0] {
		REG_LONG_PRESS   = 3'd0,
		REG_REPEAT       = 3'd1,
		REG_GROUP_HOLD   = 3'd2,
		REG_GROUP_REPEAT = 3'd3,
		REG_JUMP_STEP    = 3'd4,
		REG_ITEMS        = 3'd5,
		REG_GROUP_TOTAL  = 3'd6,
		REG_SLEEP        = 3'd7
	} reg_idx_t;

	localparam logic [15:0] RST_LONG_PRESS   = 16'd1500;
	localparam logic [15:0] RST_REPEAT       = 16'd500;
	localparam logic [15:0] RST_GROUP_HOLD   = 16'd1000;
	localparam logic [15:0] RST_GROUP_REPEAT = 16'd500;
	localparam logic [7:0]  RST_JUMP_STEP    = 8'd3;
	localparam logic [8:0]  RST_ITEMS        = 9'd5;
	localparam logic [3:0]  RST_GROUP_TOTAL  = 4'd8;
	localparam logic [31:0] RST_SLEEP        = 32'd180000;

	localparam logic [31:0] QUIET_MS = 32'd2000;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 16;

	typedef struct packed {
		logic [31:0] sleep_timeout_ms;
		logic [3:0]  group_total;
		logic [8:0]  items_per_group;
		logic [7:0]  jump_step;
		logic [15:0] group_repeat_ms;
		logic [15:0] group_hold_ms;
		logic [15:0] repeat_ms;
		logic [15:0] long_press_ms;
	} cfg_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        group_down;
		logic        next_down;
		logic        prev_down;
	} tick_t;

	typedef struct packed {
		logic       sleep_request;
		logic       full_refresh;
		logic       label_update;
		logic [7:0] item_index;
		logic [2:0] group_index;
	} res_t;

endpackage

@@ rtl/ban_cfg.sv @@
`timescale 1ns / 1ps
module ban_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_addr,
	input  logic [31:0]         cfg_wdata,
	output ban_pkg::cfg_t       cfg
);

	ban_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ms    <= ban_pkg::RST_LONG_PRESS;
			cfg_q.repeat_ms        <= ban_pkg::RST_REPEAT;
			cfg_q.group_hold_ms    <= ban_pkg::RST_GROUP_HOLD;
			cfg_q.group_repeat_ms  <= ban_pkg::RST_GROUP_REPEAT;
			cfg_q.jump_step        <= ban_pkg::RST_JUMP_STEP;
			cfg_q.items_per_group  <= ban_pkg::RST_ITEMS;
			cfg_q.group_total      <= ban_pkg::RST_GROUP_TOTAL;
			cfg_q.sleep_timeout_ms <= ban_pkg::RST_SLEEP;
		end else if (cfg_we) begin
			unique case (ban_pkg::reg_idx_t'(cfg_addr))
				ban_pkg::REG_LONG_PRESS:   cfg_q.long_press_ms    <= cfg_wdata[15:0];
				ban_pkg::REG_REPEAT:       cfg_q.repeat_ms        <= cfg_wdata[15:0];
				ban_pkg::REG_GROUP_HOLD:   cfg_q.group_hold_ms    <= cfg_wdata[15:0];
				ban_pkg::REG_GROUP_REPEAT: cfg_q.group_repeat_ms  <= cfg_wdata[15:0];
				ban_pkg::REG_JUMP_STEP:    cfg_q.jump_step        <= cfg_wdata[7:0];
				ban_pkg::REG_ITEMS:        cfg_q.items_per_group  <= cfg_wdata[8:0];
				ban_pkg::REG_GROUP_TOTAL:  cfg_q.group_total      <= cfg_wdata[3:0];
				ban_pkg::REG_SLEEP:        cfg_q.sleep_timeout_ms <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/ban_nav.sv @@
`timescale 1ns / 1ps
module ban_nav #(
	parameter int MAX_ITEMS  = 256,
	parameter int MAX_GROUPS = 8,
	parameter int TIME_BITS  = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  ban_pkg::tick_t tick,
	input  ban_pkg::cfg_t  cfg,
	output ban_pkg::res_t  res
);

	localparam int IW  = $clog2(MAX_ITEMS);
	localparam int CW  = $clog2(MAX_ITEMS + 1);
	localparam int AW  = ((CW > 9) ? CW : 9) + 1;
	localparam int GW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int GCW = $clog2(MAX_GROUPS + 1);
	localparam int GAW = ((GCW > 4) ? GCW : 4) + 1;
	localparam int TB  = TIME_BITS;
	localparam int EW  = (TB > 32) ? TB : 32;

	function automatic logic [EW-1:0] elapsed(input logic [TB-1:0] a, input logic [TB-1:0] b);
		logic [TB-1:0] d;
		d = a - b;
		return EW'(d);
	endfunction

	function automatic logic [IW-1:0] step_item(input logic [IW-1:0] item,
			input logic [AW-1:0] cnt, input logic [AW-1:0] amt, input logic fwd);
		logic [AW-1:0] c;
		logic [AW-1:0] s;
		c = (AW'(item) >= cnt) ? '0 : AW'(item);
		if (fwd) begin
			s = c + amt;
			s = (s >= cnt) ? s - cnt : s;
		end else begin
			s = (c >= amt) ? c - amt : c + cnt - amt;
		end
		return s[IW-1:0];
	endfunction

	logic [2:0]    lvl_q;
	logic [2:0]    held_q;
	logic [TB-1:0] press_q [3];
	logic [TB-1:0] rep_q [3];
	logic [GW-1:0] group_q;
	logic [IW-1:0] item_q;
	logic [TB-1:0] act_q;
	logic          pend_q;

	logic [2:0]    lvl, rise, fall, held_n, fire;
	logic [1:0]    short_p;
	logic [TB-1:0] now_t;
	logic [EW-1:0] now_w;
	logic [TB-1:0] press_n [3];
	logic [TB-1:0] rep_n [3];
	logic [EW-1:0] hold_el [3];
	logic [EW-1:0] rep_el [3];
	logic [15:0]   hold_thr [3];
	logic [15:0]   rep_thr [3];
	logic [AW-1:0] ipg, cnt, jmp, amt0, amt1;
	logic [GAW-1:0] gtot, gcnt, gnext;
	logic [IW-1:0] item_a, item_b, item_n;
	logic [GW-1:0] group_n;
	logic          mv0, mv1, moved, pend_a, pend_n, refresh, sleep_r;
	logic [TB-1:0] act_a, act_n;
	logic [EW-1:0] quiet_el;

	always_comb begin
		now_w = EW'(tick.now_ms);
		now_t = now_w[TB-1:0];
		lvl = {tick.group_down, tick.next_down, tick.prev_down};

		hold_thr[0] = cfg.long_press_ms;
		hold_thr[1] = cfg.long_press_ms;
		hold_thr[2] = cfg.group_hold_ms;
		rep_thr[0] = cfg.repeat_ms;
		rep_thr[1] = cfg.repeat_ms;
		rep_thr[2] = cfg.group_repeat_ms;

		for (int k = 0; k < 3; k++) begin
			rise[k] = lvl[k] & ~lvl_q[k];
			fall[k] = ~lvl[k] & lvl_q[k];
			press_n[k] = rise[k] ? now_t : press_q[k];
			held_n[k] = (rise[k] | held_q[k]) & ~fall[k];
			hold_el[k] = elapsed(now_t, press_n[k]);
			rep_el[k] = elapsed(now_t, rep_q[k]);
			fire[k] = held_n[k] && (hold_el[k] >= EW'(hold_thr[k]))
				&& (rep_el[k] >= EW'(rep_thr[k]));
			rep_n[k] = fire[k] ? now_t : rep_q[k];
		end

		for (int k = 0; k < 2; k++) begin
			short_p[k] = fall[k] && (hold_el[k] < EW'(cfg.long_press_ms));
		end

		ipg = AW'(cfg.items_per_group);
		if (ipg == '0)
			cnt = AW'(1);
		else if (ipg > AW'(MAX_ITEMS))
			cnt = AW'(MAX_ITEMS);
		else
			cnt = ipg;
		jmp = (AW'(cfg.jump_step) > cnt) ? cnt : AW'(cfg.jump_step);

		mv0 = short_p[0] | fire[0];
		mv1 = short_p[1] | fire[1];
		amt0 = short_p[0] ? AW'(1) : jmp;
		amt1 = short_p[1] ? AW'(1) : jmp;
		item_a = mv0 ? step_item(item_q, cnt, amt0, 1'b0) : item_q;
		item_b = mv1 ? step_item(item_a, cnt, amt1, 1'b1) : item_a;

		gtot = GAW'(cfg.group_total);
		if (gtot == '0)
			gcnt = GAW'(1);
		else if (gtot > GAW'(MAX_GROUPS))
			gcnt = GAW'(MAX_GROUPS);
		else
			gcnt = gtot;
		gnext = GAW'(group_q) + GAW'(1);
		if (fire[2]) begin
			group_n = (gnext >= gcnt) ? '0 : gnext[GW-1:0];
			item_n = '0;
		end else begin
			group_n = group_q;
			item_n = item_b;
		end

		moved = mv0 | mv1 | fire[2];
		act_a = moved ? now_t : act_q;
		pend_a = pend_q | moved;
		quiet_el = elapsed(now_t, act_a);
		refresh = pend_a && (quiet_el > EW'(ban_pkg::QUIET_MS));
		pend_n = pend_a & ~refresh;
		sleep_r = quiet_el > EW'(cfg.sleep_timeout_ms);
		act_n = sleep_r ? now_t : act_a;

		res.group_index = 3'(group_n);
		res.item_index = 8'(item_n);
		res.label_update = moved;
		res.full_refresh = refresh;
		res.sleep_request = sleep_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
			held_q <= '0;
			for (int k = 0; k < 3; k++) begin
				press_q[k] <= '0;
				rep_q[k] <= '0;
			end
			group_q <= '0;
			item_q <= '0;
			act_q <= '0;
			pend_q <= 1'b0;
		end else if (step) begin
			lvl_q <= lvl;
			held_q <= held_n;
			for (int k = 0; k < 3; k++) begin
				press_q[k] <= press_n[k];
				rep_q[k] <= rep_n[k];
			end
			group_q <= group_n;
			item_q <= item_n;
			act_q <= act_n;
			pend_q <= pend_n;
		end
	end

endmodule

@@ rtl/button_autorepeat_navigator.sv @@
`timescale 1ns / 1ps
// Two register stages: the accepted tick is held in the input stage, and the result
// register loads from it once the output stage is empty or being read.
// Throughput: one tick per clock while m_tready stays high; the next-state logic is a
// single pass from input stage to result register; both stages hold under backpressure.
// Reset: registers return to their default values, key/timer/selection state
// clears to zero, both stages empty.
`include "button_autorepeat_navigator_defines.svh"
module button_autorepeat_navigator #(
	parameter int MAX_ITEMS  = 256,
	parameter int MAX_GROUPS = 8,
	parameter int TIME_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// prev_down, next_down, group_down, now_ms[31:0], zero pad
	input  logic [ban_pkg::S_TDATA_W-1:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// group_index[2:0], item_index[7:0], label_update, full_refresh, sleep_request, zero pad
	output logic [ban_pkg::M_TDATA_W-1:0] m_tdata
);

	ban_pkg::cfg_t  cfg;
	ban_pkg::tick_t tick_s1;
	ban_pkg::res_t  res;
	ban_pkg::res_t  res_s2;
	logic           valid_s1;
	logic           valid_s2;
	logic           adv;
	logic           s_fire;

	ban_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ban_nav #(
		.MAX_ITEMS  (MAX_ITEMS),
		.MAX_GROUPS (MAX_GROUPS),
		.TIME_BITS  (TIME_BITS)
	) u_nav (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.tick   (tick_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			tick_s1.prev_down  <= s_tdata[0];
			tick_s1.next_down  <= s_tdata[1];
			tick_s1.group_down <= s_tdata[2];
			tick_s1.now_ms     <= s_tdata[34:3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2.sleep_request, res_s2.full_refresh,
		res_s2.label_update, res_s2.item_index, res_s2.group_index};

	`BAN_ASSERT_IMPL(a_ready_when_out_empty, !valid_s2, s_tready)
	`BAN_ASSERT_NEXT(a_adv_fills_output, adv, valid_s2)
	`BAN_ASSERT_IMPL(a_move_blocks_refresh, valid_s2, !(res_s2.label_update && res_s2.full_refresh))

endmodule

@@ tb/sv/navigator_checker.sv @@
`timescale 1ns / 1ps
module navigator_checker
	import ban_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_addr,
	input  logic [31:0]          cfg_wdata,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	// prev_down, next_down, group_down, now_ms[31:0], zero pad
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	// group_index[2:0], item_index[7:0], label_update, full_refresh, sleep_request, zero pad
	input  logic [M_TDATA_W-1:0] m_tdata,
	output int                   mismatches,
	output int                   pending
);

	localparam int MAX_ITEMS  = 256;
	localparam int MAX_GROUPS = 8;

	cfg_t        cfg;
	logic [2:0]  key_was;
	logic [2:0]  key_held;
	logic [31:0] press_at [3];
	logic [31:0] repeat_at [3];
	logic [31:0] active_at;
	int unsigned group_sel;
	int unsigned item_sel;
	bit          redraw_pending;
	res_t        expected_sel [$];
	res_t        want;
	res_t        got;
	tick_t       tk;

	function automatic int unsigned step_item(int unsigned cur_in, int unsigned span,
			int unsigned amount, bit forward);
		int unsigned cur;
		cur = (cur_in >= span) ? 0 : cur_in;
		if (forward) begin
			return (cur + amount >= span) ? cur + amount - span : cur + amount;
		end
		return (cur >= amount) ? cur - amount : cur + span - amount;
	endfunction

	function automatic void advance_navigation(tick_t t);
		logic [2:0]  levels;
		logic [31:0] now;
		logic [31:0] held_for;
		logic [31:0] since_rep;
		logic [31:0] quiet;
		int unsigned span;
		int unsigned jump;
		int unsigned groups;
		int unsigned nxt;
		res_t        r;
		bit          moved;
		levels = {t.group_down, t.next_down, t.prev_down};
		now = t.now_ms;
		span = (cfg.items_per_group == 0) ? 1 :
			(cfg.items_per_group > MAX_ITEMS) ? MAX_ITEMS : cfg.items_per_group;
		jump = (cfg.jump_step > span) ? span : cfg.jump_step;
		groups = (cfg.group_total == 0) ? 1 :
			(cfg.group_total > MAX_GROUPS) ? MAX_GROUPS : cfg.group_total;
		moved = 1'b0;

		for (int k = 0; k < 2; k++) begin
			if (levels[k] && !key_was[k]) begin
				key_held[k] = 1'b1;
				press_at[k] = now;
			end
			if (!levels[k] && key_was[k]) begin
				held_for = now - press_at[k];
				if (held_for < cfg.long_press_ms) begin
					item_sel = step_item(item_sel, span, 1, k == 1);
					moved = 1'b1;
					redraw_pending = 1'b1;
					active_at = now;
				end
				key_held[k] = 1'b0;
			end
			held_for = now - press_at[k];
			since_rep = now - repeat_at[k];
			if (key_held[k] && held_for >= cfg.long_press_ms && since_rep >= cfg.repeat_ms) begin
				item_sel = step_item(item_sel, span, jump, k == 1);
				repeat_at[k] = now;
				moved = 1'b1;
				redraw_pending = 1'b1;
				active_at = now;
			end
		end

		if (levels[2] && !key_was[2]) begin
			key_held[2] = 1'b1;
			press_at[2] = now;
		end
		if (!levels[2] && key_was[2]) begin
			key_held[2] = 1'b0;
		end
		held_for = now - press_at[2];
		since_rep = now - repeat_at[2];
		if (key_held[2] && held_for >= cfg.group_hold_ms && since_rep >= cfg.group_repeat_ms) begin
			nxt = group_sel + 1;
			group_sel = (nxt >= groups) ? 0 : nxt;
			item_sel = 0;
			repeat_at[2] = now;
			moved = 1'b1;
			redraw_pending = 1'b1;
			active_at = now;
		end

		key_was = levels;
		quiet = now - active_at;
		r.full_refresh = 1'b0;
		if (redraw_pending && quiet > QUIET_MS) begin
			r.full_refresh = 1'b1;
			redraw_pending = 1'b0;
		end
		r.sleep_request = 1'b0;
		if (quiet > cfg.sleep_timeout_ms) begin
			r.sleep_request = 1'b1;
			active_at = now;
		end
		r.group_index = group_sel[2:0];
		r.item_index = item_sel[7:0];
		r.label_update = moved;
		expected_sel.push_back(r);
	endfunction

	function automatic void check_field(string field, int unsigned want_v, int unsigned got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, got %0d", field, want_v, got_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.long_press_ms = RST_LONG_PRESS;
			cfg.repeat_ms = RST_REPEAT;
			cfg.group_hold_ms = RST_GROUP_HOLD;
			cfg.group_repeat_ms = RST_GROUP_REPEAT;
			cfg.jump_step = RST_JUMP_STEP;
			cfg.items_per_group = RST_ITEMS;
			cfg.group_total = RST_GROUP_TOTAL;
			cfg.sleep_timeout_ms = RST_SLEEP;
			key_was = '0;
			key_held = '0;
			for (int k = 0; k < 3; k++) begin
				press_at[k] = '0;
				repeat_at[k] = '0;
			end
			active_at = '0;
			group_sel = 0;
			item_sel = 0;
			redraw_pending = 1'b0;
			expected_sel.delete();
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(res_t)-1:0];
				if (expected_sel.size() == 0) begin
					$error("result with nothing expected: m_tdata %h", m_tdata);
					mismatches++;
				end else begin
					want = expected_sel.pop_front();
					check_field("group_index", want.group_index, got.group_index);
					check_field("item_index", want.item_index, got.item_index);
					check_field("label_update", want.label_update, got.label_update);
					check_field("full_refresh", want.full_refresh, got.full_refresh);
					check_field("sleep_request", want.sleep_request, got.sleep_request);
					check_field("pad", 0, m_tdata[M_TDATA_W-1:$bits(res_t)]);
				end
			end
			if (s_tvalid && s_tready) begin
				tk = s_tdata[$bits(tick_t)-1:0];
				advance_navigation(tk);
			end
			if (cfg_we) begin
				case (cfg_addr)
					REG_LONG_PRESS:   cfg.long_press_ms = cfg_wdata[15:0];
					REG_REPEAT:       cfg.repeat_ms = cfg_wdata[15:0];
					REG_GROUP_HOLD:   cfg.group_hold_ms = cfg_wdata[15:0];
					REG_GROUP_REPEAT: cfg.group_repeat_ms = cfg_wdata[15:0];
					REG_JUMP_STEP:    cfg.jump_step = cfg_wdata[7:0];
					REG_ITEMS:        cfg.items_per_group = cfg_wdata[8:0];
					REG_GROUP_TOTAL:  cfg.group_total = cfg_wdata[3:0];
					default:          cfg.sleep_timeout_ms = cfg_wdata;
				endcase
			end
			pending = expected_sel.size();
		end
	end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
	import ban_pkg::*;

	localparam int unsigned ITEM_TARGET = 890;
	localparam logic [2:0] NO_KEYS   = 3'b000;
	localparam logic [2:0] KEY_PREV  = 3'b001;
	localparam logic [2:0] KEY_NEXT  = 3'b010;
	localparam logic [2:0] KEY_GROUP = 3'b100;
	localparam logic [2:0] ALL_KEYS  = 3'b111;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [2:0]           cfg_addr = '0;
	logic [31:0]          cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	int                   mismatches;
	int                   pending;

	logic [31:0] t_ms = '0;
	int unsigned sent = 0;
	int unsigned burst_left = 0;
	int unsigned lp_ms = RST_LONG_PRESS;
	int unsigned rp_ms = RST_REPEAT;
	int unsigned gh_ms = RST_GROUP_HOLD;
	int unsigned gr_ms = RST_GROUP_REPEAT;
	int unsigned sleep_ms = RST_SLEEP;
	rx_mode_t    rx_mode = RX_OPEN;
	int unsigned rx_left = 0;
	int unsigned rx_phase = 0;
	int unsigned phase;

	button_autorepeat_navigator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	navigator_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.mismatches(mismatches),
		.pending(pending)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(10, 150);
		end
		rx_left--;
		rx_phase++;
		case (rx_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_tready <= ($urandom_range(0, 4) == 0);
			default:   m_tready <= (rx_phase % 3 != 0);
		endcase
	end

	task automatic send_tick(input logic [2:0] keys, input logic [31:0] now);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 40);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= S_TDATA_W'({now, keys});
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// hold keys until hold_ms has passed or 40 further ticks are sent, then release
	task automatic gesture(input logic [2:0] keys, input int unsigned hold_ms);
		logic [31:0] start;
		int unsigned stride;
		int unsigned n;
		stride = hold_ms / 6 + 1;
		start = t_ms;
		n = 0;
		send_tick(keys, t_ms);
		while ((t_ms - start) < hold_ms && n < 40) begin
			t_ms += $urandom_range(1, stride);
			send_tick(keys, t_ms);
			n++;
		end
		t_ms += $urandom_range(1, stride);
		send_tick(NO_KEYS, t_ms);
	endtask

	task automatic run_gestures(input int unsigned count);
		int unsigned goal;
		int unsigned pick;
		logic [2:0]  key;
		goal = sent + count;
		while (sent < goal) begin
			pick = $urandom_range(0, 99);
			key = $urandom_range(0, 1) ? KEY_NEXT : KEY_PREV;
			if (pick < 30) begin
				gesture(key, $urandom_range(0, lp_ms));
			end else if (pick < 55) begin
				gesture(key, lp_ms + $urandom_range(0, 6) * rp_ms);
			end else if (pick < 70) begin
				gesture(KEY_GROUP, gh_ms + $urandom_range(0, 4) * gr_ms);
			end else if (pick < 80) begin
				t_ms += $urandom_range(1000, 4000);
				send_tick(NO_KEYS, t_ms);
			end else if (pick < 85) begin
				t_ms += sleep_ms + $urandom_range(0, 2);
				send_tick(NO_KEYS, t_ms);
			end else if (pick < 95) begin
				repeat ($urandom_range(2, 6)) begin
					t_ms += $urandom_range(0, 400);
					send_tick(3'($urandom_range(0, 7)), t_ms);
				end
			end else begin
				t_ms = $urandom;
				send_tick(3'($urandom_range(0, 7)), t_ms);
			end
		end
	endtask

	// drop the request and hold until every result has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value, input int width,
			input bit junk);
		logic [31:0] data;
		data = value;
		if (junk && width < 32) begin
			data = data | ($urandom << width);
		end
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	task automatic apply_settings(input int unsigned lp, input int unsigned rp,
			input int unsigned gh, input int unsigned gr, input int unsigned js,
			input int unsigned ipg, input int unsigned gt, input int unsigned slp,
			input bit junk);
		settle();
		write_reg(REG_LONG_PRESS, lp, 16, junk);
		write_reg(REG_REPEAT, rp, 16, junk);
		write_reg(REG_GROUP_HOLD, gh, 16, junk);
		write_reg(REG_GROUP_REPEAT, gr, 16, junk);
		write_reg(REG_JUMP_STEP, js, 8, junk);
		write_reg(REG_ITEMS, ipg, 9, junk);
		write_reg(REG_GROUP_TOTAL, gt, 4, junk);
		write_reg(REG_SLEEP, slp, 32, junk);
		cfg_we <= 1'b0;
		lp_ms = lp;
		rp_ms = rp;
		gh_ms = gh;
		gr_ms = gr;
		sleep_ms = slp;
	endtask

	function automatic int unsigned pick_ms(input int unsigned typical);
		return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, typical);
	endfunction

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_tick(NO_KEYS, 32'd0);
		send_tick(KEY_PREV, 32'd100);
		send_tick(NO_KEYS, 32'd200);
		send_tick(KEY_NEXT, 32'd300);
		send_tick(NO_KEYS, 32'd400);
		send_tick(KEY_NEXT, 32'd500);
		send_tick(KEY_NEXT, 32'd1000);
		send_tick(KEY_NEXT, 32'd2100);
		send_tick(KEY_NEXT, 32'd2400);
		send_tick(KEY_NEXT, 32'd2700);
		send_tick(NO_KEYS, 32'd2800);
		send_tick(KEY_PREV, 32'd3000);
		send_tick(KEY_PREV, 32'd4600);
		send_tick(NO_KEYS, 32'd4700);
		send_tick(KEY_GROUP, 32'd5000);
		send_tick(KEY_GROUP, 32'd6100);
		send_tick(KEY_GROUP, 32'd6700);
		send_tick(NO_KEYS, 32'd6800);
		send_tick(NO_KEYS, 32'd9000);
		send_tick(NO_KEYS, 32'd186701);
		send_tick(ALL_KEYS, 32'd186800);
		send_tick(NO_KEYS, 32'd186900);
		send_tick(KEY_PREV, 32'hFFFF_FF00);
		send_tick(NO_KEYS, 32'h0000_0010);
		send_tick(NO_KEYS, 32'hFFFF_FFFF);
		t_ms = 32'd200000;

		run_gestures(70);
		phase = 1;
		while (sent < ITEM_TARGET) begin
			case (phase)
				1: apply_settings(1, 1, 1, 1, 255, 256, 8, 5000, 1'b0);
				2: apply_settings(65535, 65535, 65535, 65535, 0, 0, 0, 32'hFFFF_FFFF, 1'b0);
				3: apply_settings(200, 100, 300, 150, 7, 511, 15, 1, 1'b0);
				4: apply_settings(0, 0, 0, 0, 200, 37, 3, 0, 1'b0);
				default: begin
					case ($urandom_range(0, 3))
						0: sleep_ms = $urandom_range(0, 3000);
						1: sleep_ms = $urandom_range(3000, 60000);
						2: sleep_ms = RST_SLEEP;
						default: sleep_ms = $urandom;
					endcase
					apply_settings(pick_ms(3000), pick_ms(1000), pick_ms(3000), pick_ms(1000),
						$urandom_range(0, 255), $urandom_range(0, 511), $urandom_range(0, 15),
						sleep_ms, 1'($urandom_range(0, 1)));
				end
			endcase
			if ($urandom_range(0, 2) == 0) begin
				t_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
			end
			run_gestures(90);
			phase++;
		end

		settle();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
